>>> rtl/ckre_pkg.sv
// Shared constants and types of the color key run extractor.
package ckre_pkg;

    // Raster limits; pixels beyond them count as transparent.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int XPOS_W  = $clog2(MAX_WIDTH + 1);
    localparam int YPOS_W  = $clog2(MAX_HEIGHT + 1);
    localparam int COORD_W = 11;
    localparam int RUN_W   = 20;
    localparam int BYTE_W  = 8;

    typedef logic [XPOS_W-1:0]  t_xpos;
    typedef logic [YPOS_W-1:0]  t_ypos;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [RUN_W-1:0]   t_run;
    typedef logic [BYTE_W-1:0]  t_byte;

    localparam t_xpos X_LIMIT = t_xpos'(MAX_WIDTH);
    localparam t_ypos Y_LIMIT = t_ypos'(MAX_HEIGHT);
    localparam t_run  RUN_MAX = '1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MID  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL_MID  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL_HIGH = 3'd5;

    localparam t_byte KEY_RESET = 8'hFF;
    localparam t_byte TOL_RESET = 8'h00;

    // Result queue; depth must be a power of two and at least 2.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic clear;
        logic row_end;
        logic frame_end;
    } t_pix_item;

    typedef struct packed {
        logic   is_summary;
        t_coord x_begin;
        t_coord x_end;
        t_coord y_top;
        t_coord y_bottom;
        t_run   run_total;
        logic   last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

>>> rtl/color_key_run_extractor_unit.sv
// Top level of the color key run extractor.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata pixel bytes, tlast frame end, tuser row end
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata run or box, tlast last, tuser summary
//  cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index register, i_cfg_data byte
//
// One pixel per cycle while s_axis_tready is high. A pixel is classified at the port,
// registered, and its run and box update lands in a four-entry result queue. A pixel that
// closes a run at frame end pushes two results; the queue drains one per cycle while
// m_axis_tready is high, and s_axis_tready drops while a pixel is held and fewer than two
// queue entries are free. Reset (synchronous, active low) restores keys to 0xFF, tolerances
// to 0 and clears the frame state; no clearing pass is needed. Config writes are always taken.
module color_key_run_extractor_unit
    import ckre_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // pixel stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,  // pix_low, pix_mid, pix_high
    input  logic                 s_axis_tlast,  // frame_end
    input  logic                 s_axis_tuser,  // row_end
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,  // x_begin, x_end, y_top, y_bottom, run_total
    output logic                 m_axis_tlast,  // last
    output logic                 m_axis_tuser,  // is_summary
    // configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    logic      pix_clear;
    t_pix_item pix_item;
    logic      queue_room;
    t_push     push;
    t_result   res;

    // Registers take every write request.
    assign o_cfg_ready = 1'b1;

    ckre_key_match u_key_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_write (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix_low   (s_axis_tdata[7:0]),
        .i_pix_mid   (s_axis_tdata[15:8]),
        .i_pix_high  (s_axis_tdata[23:16]),
        .o_clear     (pix_clear)
    );

    // Carry only the transparency flag and the row and frame marks forward.
    assign pix_item.clear     = pix_clear;
    assign pix_item.row_end   = s_axis_tuser;
    assign pix_item.frame_end = s_axis_tlast;

    ckre_run_tracker u_run_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (pix_item),
        .i_room  (queue_room),
        .o_push  (push)
    );

    ckre_result_fifo u_result_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (queue_room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (res)
    );

    // Pack result fields from the lowest bit up.
    assign m_axis_tdata = {res.run_total, res.y_bottom, res.y_top, res.x_end, res.x_begin};
    assign m_axis_tlast = res.last;
    assign m_axis_tuser = res.is_summary;

endmodule

>>> rtl/ckre_key_match.sv
// Key and tolerance registers and the per-pixel transparency test.
module ckre_key_match
    import ckre_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_write,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  t_byte                i_cfg_data,
    input  t_byte                i_pix_low,
    input  t_byte                i_pix_mid,
    input  t_byte                i_pix_high,
    output logic                 o_clear
);

    t_byte r_key_low, r_key_mid, r_key_high;
    t_byte r_tol_low, r_tol_mid, r_tol_high;

    // Upper bound saturates at 255: a 9-bit sum compared to the byte does that.
    function automatic logic byte_in_key(input t_byte b, input t_byte key, input t_byte tol);
        logic [BYTE_W:0] hi;
        hi = {1'b0, key} + {1'b0, tol};
        return (b >= key) && ({1'b0, b} <= hi);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= KEY_RESET;
            r_key_mid  <= KEY_RESET;
            r_key_high <= KEY_RESET;
            r_tol_low  <= TOL_RESET;
            r_tol_mid  <= TOL_RESET;
            r_tol_high <= TOL_RESET;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                CFG_KEY_MID:  r_key_mid  <= i_cfg_data;
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_TOL_LOW:  r_tol_low  <= i_cfg_data;
                CFG_TOL_MID:  r_tol_mid  <= i_cfg_data;
                CFG_TOL_HIGH: r_tol_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_clear = byte_in_key(i_pix_low,  r_key_low,  r_tol_low)
                  && byte_in_key(i_pix_mid,  r_key_mid,  r_tol_mid)
                  && byte_in_key(i_pix_high, r_key_high, r_tol_high);

endmodule

>>> rtl/ckre_run_tracker.sv
// Input register, run and bounding box state, and result formation.
module ckre_run_tracker
    import ckre_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_pix_item i_item,
    input  logic      i_room,
    output t_push     o_push
);

    logic      r_valid;
    t_pix_item r_item;
    t_xpos     r_col, n_col;
    t_ypos     r_row, n_row;
    logic      r_in_run, n_in_run;
    t_xpos     r_run_start, n_run_start;
    t_xpos     r_box_left, n_box_left, box_left_upd;
    t_ypos     r_box_top, n_box_top, box_top_upd;
    t_xpos     r_box_right, n_box_right, box_right_upd;
    t_ypos     r_box_bottom, n_box_bottom, box_bottom_upd;
    t_run      r_run_count, n_run_count, count_upd;

    logic      advance;
    logic      in_area, opaque, line_end;
    logic      close_mid, close_end, run_emit;
    t_xpos     col_inc, run_x0, run_x1;
    t_ypos     row_inc, row_below;
    t_result   run_res, sum_res;

    assign advance = r_valid && i_room;
    assign o_ready = !r_valid || i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        in_area   = (r_col < X_LIMIT) && (r_row < Y_LIMIT);
        opaque    = in_area && !r_item.clear;
        line_end  = r_item.row_end || r_item.frame_end;
        col_inc   = (r_col < X_LIMIT) ? r_col + t_xpos'(1) : r_col;
        row_inc   = (r_row < Y_LIMIT) ? r_row + t_ypos'(1) : r_row;
        row_below = r_row + t_ypos'(1);

        // A run ends at a transparent pixel or at the end of its row.
        close_mid = r_in_run && !opaque;
        close_end = opaque && line_end;
        run_emit  = close_mid || close_end;
        run_x0    = r_in_run ? r_run_start : r_col;
        run_x1    = close_mid ? r_col : col_inc;

        box_left_upd   = r_box_left;
        box_top_upd    = r_box_top;
        box_right_upd  = r_box_right;
        box_bottom_upd = r_box_bottom;
        count_upd      = r_run_count;
        if (run_emit) begin
            if (run_x0 < r_box_left)     box_left_upd   = run_x0;
            if (r_row < r_box_top)       box_top_upd    = r_row;
            if (run_x1 > r_box_right)    box_right_upd  = run_x1;
            if (row_below > r_box_bottom) box_bottom_upd = row_below;
            if (r_run_count != RUN_MAX)  count_upd      = r_run_count + t_run'(1);
        end

        run_res.is_summary = 1'b0;
        run_res.x_begin    = t_coord'(run_x0);
        run_res.x_end      = t_coord'(run_x1);
        run_res.y_top      = t_coord'(r_row);
        run_res.y_bottom   = t_coord'(row_below);
        run_res.run_total  = count_upd;
        run_res.last       = !r_item.frame_end;

        sum_res.is_summary = 1'b1;
        sum_res.x_begin    = t_coord'(box_left_upd);
        sum_res.x_end      = t_coord'(box_right_upd);
        sum_res.y_top      = t_coord'(box_top_upd);
        sum_res.y_bottom   = t_coord'(box_bottom_upd);
        sum_res.run_total  = count_upd;
        sum_res.last       = 1'b1;

        // Pack results in order: run first, then summary.
        o_push.count  = advance ? {1'b0, run_emit} + {1'b0, r_item.frame_end} : 2'd0;
        o_push.first  = run_emit ? run_res : sum_res;
        o_push.second = sum_res;

        n_col        = line_end ? '0 : col_inc;
        n_row        = line_end ? row_inc : r_row;
        n_in_run     = opaque && !line_end;
        n_run_start  = (opaque && !r_in_run) ? r_col : r_run_start;
        n_box_left   = box_left_upd;
        n_box_top    = box_top_upd;
        n_box_right  = box_right_upd;
        n_box_bottom = box_bottom_upd;
        n_run_count  = count_upd;
        if (r_item.frame_end) begin
            n_col        = '0;
            n_row        = '0;
            n_in_run     = 1'b0;
            n_run_start  = '0;
            n_box_left   = X_LIMIT;
            n_box_top    = Y_LIMIT;
            n_box_right  = '0;
            n_box_bottom = '0;
            n_run_count  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_in_run     <= 1'b0;
            r_run_start  <= '0;
            r_box_left   <= X_LIMIT;
            r_box_top    <= Y_LIMIT;
            r_box_right  <= '0;
            r_box_bottom <= '0;
            r_run_count  <= '0;
        end else if (advance) begin
            r_col        <= n_col;
            r_row        <= n_row;
            r_in_run     <= n_in_run;
            r_run_start  <= n_run_start;
            r_box_left   <= n_box_left;
            r_box_top    <= n_box_top;
            r_box_right  <= n_box_right;
            r_box_bottom <= n_box_bottom;
            r_run_count  <= n_run_count;
        end
    end

endmodule

>>> rtl/ckre_result_fifo.sv
// Result queue: takes up to two results a cycle, hands out one while i_ready is high.
module ckre_result_fifo
    import ckre_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, r_rd;
    logic [FIFO_CW-1:0]   r_count;
    logic                 pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    // Room for the worst case of two pushes; a pop in the same cycle is not counted.
    assign o_room  = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + FIFO_AW'(1)] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + FIFO_AW'(i_push.count);
            r_rd    <= r_rd + FIFO_AW'(pop);
            r_count <= r_count + FIFO_CW'(i_push.count) - FIFO_CW'(pop);
        end
    end

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the color key run extractor: pixel frames in, run and box records checked.
module testbench
    import ckre_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Receiver hold-off length for the backpressure test, and the overall cycle budget.
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 500000;
    // Cycles to let the pipeline empty when a pixel produced no record.
    localparam int SETTLE_CYCLES = 8;

    // Clock, reset and every DUT input start at a known value.
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata  = '0;  // pix_low, pix_mid, pix_high
    logic                 s_axis_tlast  = 1'b0; // frame_end
    logic                 s_axis_tuser  = 1'b0; // row_end
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [63:0]          m_axis_tdata;  // x_begin, x_end, y_top, y_bottom, run_total
    logic                 m_axis_tlast;  // last
    logic                 m_axis_tuser;  // is_summary
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [BYTE_W-1:0]    i_cfg_data    = '0;

    color_key_run_extractor_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the key registers and frame state.
    // ------------------------------------------------------------------
    t_byte   key_lo, key_mid, key_hi;
    t_byte   tol_lo, tol_mid, tol_hi;
    t_xpos   col_pos, run_start, box_left, box_right;
    t_ypos   row_pos, box_top, box_bottom;
    logic    in_run;
    t_run    run_cnt;

    // Records the block still owes us, oldest first.
    t_result pending_records[$];

    // Idle control shared by the sender, the receiver and the tests.
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int hold_req      = 0;  // bump to ask the receiver for a long hold-off
    int hold_seen     = 0;
    int hold_left     = 0;

    // Bookkeeping for the run summary.
    int errors       = 0;
    int pixels_sent  = 0;
    int records_seen = 0;
    int frames_sent  = 0;
    int key_settings = 0;
    int cycle_cnt    = 0;

    // Drop all frame state back to an empty frame.
    function automatic void restart_frame();
        col_pos    = '0;
        row_pos    = '0;
        in_run     = 1'b0;
        run_start  = '0;
        box_left   = X_LIMIT;
        box_top    = Y_LIMIT;
        box_right  = '0;
        box_bottom = '0;
        run_cnt    = '0;
    endfunction

    // Transparent byte test: key <= b <= key + tol, upper limit saturating at 0xFF.
    function automatic bit byte_in_key(t_byte b, t_byte key, t_byte tol);
        logic [8:0] top;
        top = {1'b0, key} + {1'b0, tol};
        if (top > 9'h0FF)
            top = 9'h0FF;
        return ({1'b0, b} >= {1'b0, key}) && ({1'b0, b} <= top);
    endfunction

    // Close the open run at [x0, x1) on the current row; grow the box and count it.
    function automatic t_result close_run(t_xpos x0, t_xpos x1);
        t_result r;
        if (x0 < box_left)
            box_left = x0;
        if (row_pos < box_top)
            box_top = row_pos;
        if (x1 > box_right)
            box_right = x1;
        if (row_pos + 1 > box_bottom)
            box_bottom = t_ypos'(row_pos + 1);
        if (run_cnt != RUN_MAX)
            run_cnt++;
        r = '{1'b0, t_coord'(x0), t_coord'(x1), t_coord'(row_pos), t_coord'(row_pos + 1),
              run_cnt, 1'b0};
        return r;
    endfunction

    // Work out the records one accepted pixel causes and queue them in order:
    // a run closed by this pixel first, the frame summary second.
    function automatic void predict_pixel(t_byte lo, t_byte mid, t_byte hi,
                                          bit row_end, bit frame_end);
        t_result res[2];
        int      n;
        bit      in_area;
        bit      keyed;
        n       = 0;
        in_area = (col_pos < X_LIMIT) && (row_pos < Y_LIMIT);
        keyed   = byte_in_key(lo, key_lo, tol_lo) && byte_in_key(mid, key_mid, tol_mid) &&
                  byte_in_key(hi, key_hi, tol_hi);
        if (in_area && !keyed) begin
            if (!in_run) begin
                in_run    = 1'b1;
                run_start = col_pos;
            end
        end else if (in_run) begin
            res[n] = close_run(run_start, col_pos);
            n++;
            in_run = 1'b0;
        end
        // Column saturates at the raster width, so an over-long row closes there.
        if (col_pos < X_LIMIT)
            col_pos++;
        if (row_end || frame_end) begin
            if (in_run) begin
                res[n] = close_run(run_start, col_pos);
                n++;
                in_run = 1'b0;
            end
            col_pos = '0;
            if (row_pos < Y_LIMIT)
                row_pos++;
        end
        if (frame_end) begin
            res[n] = '{1'b1, t_coord'(box_left), t_coord'(box_right), t_coord'(box_top),
                       t_coord'(box_bottom), run_cnt, 1'b0};
            n++;
            frames_sent++;
            restart_frame();
        end
        if (n > 0)
            res[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            pending_records.push_back(res[i]);
    endfunction

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------

    // Offer one pixel, after an optional random gap, and hold it until accepted.
    task automatic send_pixel(t_byte lo, t_byte mid, t_byte hi, bit row_end, bit frame_end);
        if ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hi, mid, lo};
        s_axis_tlast  <= frame_end;
        s_axis_tuser  <= row_end;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_pixel(lo, mid, hi, row_end, frame_end);
        pixels_sent++;
    endtask

    // Stop offering pixels, wait for every owed record, then let the pipeline settle.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_records.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one key or tolerance register; valid stays high so back-to-back writes need no gap.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, t_byte val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_KEY_LOW:  key_lo  = val;
            CFG_KEY_MID:  key_mid = val;
            CFG_KEY_HIGH: key_hi  = val;
            CFG_TOL_LOW:  tol_lo  = val;
            CFG_TOL_MID:  tol_mid = val;
            CFG_TOL_HIGH: tol_hi  = val;
            default: ;
        endcase
    endtask

    // Drain, then program all six key and tolerance registers.
    task automatic program_keys(t_byte kl, t_byte km, t_byte kh,
                                t_byte tl, t_byte tm, t_byte th);
        wait_idle();
        write_reg(CFG_KEY_LOW,  kl);
        write_reg(CFG_KEY_MID,  km);
        write_reg(CFG_KEY_HIGH, kh);
        write_reg(CFG_TOL_LOW,  tl);
        write_reg(CFG_TOL_MID,  tm);
        write_reg(CFG_TOL_HIGH, th);
        i_cfg_valid <= 1'b0;
        key_settings++;
    endtask

    // Pick a pixel byte: inside the key window, or near and around its edges.
    function automatic t_byte pick_byte(t_byte key, t_byte tol, bit want_keyed);
        int top;
        top = int'(key) + int'(tol);
        if (top > 255)
            top = 255;
        if (want_keyed)
            return t_byte'($urandom_range(top, key));
        case ($urandom_range(3))
            0:       return key - 8'd1;
            1:       return t_byte'(top + 1);
            2:       return t_byte'($urandom_range(top, key));
            default: return t_byte'($urandom);
        endcase
    endfunction

    // One well-formed frame of small random rows with random content.
    task automatic send_frame();
        int rows;
        int width;
        bit keyed;
        rows = $urandom_range(4, 1);
        for (int r = 0; r < rows; r++) begin
            width = $urandom_range(10, 1);
            for (int c = 0; c < width; c++) begin
                keyed = 1'($urandom_range(1));
                if (c == width - 1 && r == rows - 1)
                    // The frame end also ends the row, with or without the row flag.
                    send_pixel(pick_byte(key_lo, tol_lo, keyed), pick_byte(key_mid, tol_mid, keyed),
                               pick_byte(key_hi, tol_hi, keyed), 1'($urandom_range(1)), 1'b1);
                else
                    send_pixel(pick_byte(key_lo, tol_lo, keyed), pick_byte(key_mid, tol_mid, keyed),
                               pick_byte(key_hi, tol_hi, keyed), c == width - 1, 1'b0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side: stall at random, hold off on request, check each record.
    // ------------------------------------------------------------------

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_record();
        t_result want;
        records_seen++;
        if (pending_records.size() == 0) begin
            $error("record with none expected: tdata %h tuser %b tlast %b",
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
            errors++;
            return;
        end
        want = pending_records.pop_front();
        check_field("is_summary", longint'(want.is_summary), longint'(m_axis_tuser));
        check_field("x_begin",    longint'(want.x_begin),    longint'(m_axis_tdata[10:0]));
        check_field("x_end",      longint'(want.x_end),      longint'(m_axis_tdata[21:11]));
        check_field("y_top",      longint'(want.y_top),      longint'(m_axis_tdata[32:22]));
        check_field("y_bottom",   longint'(want.y_bottom),   longint'(m_axis_tdata[43:33]));
        check_field("run_total",  longint'(want.run_total),  longint'(m_axis_tdata[63:44]));
        check_field("last",       longint'(want.last),       longint'(m_axis_tlast));
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_record();
        // A new hold request starts a long stretch with tready low.
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d records still owed",
                     cycle_cnt, pending_records.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset keys 0xFF, tolerance 0: only pure white is transparent.
    task automatic test_reset_keys();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        // Row 0: run [0,1), white gap, run [2,4) closed by the row end.
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
        send_pixel(8'hFE, 8'hFF, 8'hFF, 1'b0, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFE, 1'b1, 1'b0);
        // Row 1: run closed by a white pixel that also ends the frame; two records.
        send_pixel(8'hFF, 8'hFE, 8'hFF, 1'b0, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1);
        // Single opaque pixel frames, with and without the row flag.
        send_pixel(8'h00, 8'hFF, 8'h00, 1'b0, 1'b1);
        send_pixel(8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1);
    endtask

    // Frames with no opaque pixel: summary carries the untouched box and zero runs.
    task automatic test_empty_frames();
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
    endtask

    // Window edges per byte, with the low window saturating at 0xFF.
    task automatic test_tolerance_limits();
        program_keys(8'hF0, 8'h10, 8'h00, 8'h20, 8'h05, 8'h00);
        send_pixel(8'hFF, 8'h12, 8'h00, 1'b0, 1'b0);  // keyed, top of saturated window
        send_pixel(8'hEF, 8'h12, 8'h00, 1'b0, 1'b0);  // low byte one under key
        send_pixel(8'hF0, 8'h15, 8'h00, 1'b0, 1'b0);  // keyed, both windows at edge
        send_pixel(8'hF0, 8'h16, 8'h00, 1'b0, 1'b0);  // mid byte one over top
        send_pixel(8'hF0, 8'h0F, 8'h00, 1'b1, 1'b0);  // mid byte one under key
        send_pixel(8'hF0, 8'h10, 8'h01, 1'b0, 1'b0);  // high byte, zero tolerance
        send_pixel(8'hF0, 8'h10, 8'h00, 1'b0, 1'b1);
        wait_idle();
    endtask

    // Row longer than the raster: the run is cut at the right limit.
    task automatic test_long_row();
        program_keys(KEY_RESET, KEY_RESET, KEY_RESET, TOL_RESET, TOL_RESET, TOL_RESET);
        for (int c = 0; c < MAX_WIDTH + 6; c++)
            send_pixel(8'h00, 8'h00, 8'h00, c == MAX_WIDTH + 5, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1, 1'b1);
        wait_idle();
    endtask

    // Frame taller than the raster: rows past the bottom limit are transparent.
    task automatic test_tall_frame();
        for (int r = 0; r < MAX_HEIGHT + 2; r++) begin
            if (r >= MAX_HEIGHT - 4)
                send_pixel(8'h00, 8'h00, 8'h00, 1'b1, r == MAX_HEIGHT + 1);
            else
                send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
        end
        wait_idle();
    endtask

    // Receiver holds off for a long stretch while pixels keep coming: the result
    // queue fills and s_axis_tready must drop without losing a record.
    task automatic test_output_stall();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_req++;
        for (int i = 0; i < 60; i++)
            send_pixel(i[0] ? 8'hFF : 8'h00, 8'hFF, 8'hFF, i % 3 == 2, i % 20 == 19);
        wait_idle();
    endtask

    // Random frames and noise over several key settings and idle mixes.
    task automatic test_random_traffic();
        int target;
        int half;
        bit paused;
        for (int p = 0; p < 8; p++) begin
            // Extremes first, then random keys with mostly narrow windows.
            case (p)
                0:       program_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                1:       program_keys(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
                2:       program_keys(8'h00, 8'hFF, t_byte'($urandom), 8'hFF, 8'h00,
                                      t_byte'($urandom));
                default: program_keys(t_byte'($urandom), t_byte'($urandom), t_byte'($urandom),
                                      t_byte'($urandom_range(40)), t_byte'($urandom_range(40)),
                                      t_byte'($urandom_range(255)));
            endcase
            case (p % 4)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 70; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 70; end
                default: begin snd_idle_pct = 14; rcv_stall_pct = 14; end
            endcase
            target = pixels_sent + 112;
            half   = pixels_sent + 56;
            paused = 1'b0;
            while (pixels_sent < target) begin
                // Halfway through, pause the sender until every record has come back.
                if (!paused && pixels_sent >= half) begin
                    wait_idle();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 12)
                    send_pixel(t_byte'($urandom), t_byte'($urandom), t_byte'($urandom),
                               1'($urandom_range(1)), $urandom_range(3) == 0);
                else
                    send_frame();
            end
        end
        wait_idle();
    endtask

    initial begin
        key_lo  = KEY_RESET;
        key_mid = KEY_RESET;
        key_hi  = KEY_RESET;
        tol_lo  = TOL_RESET;
        tol_mid = TOL_RESET;
        tol_hi  = TOL_RESET;
        restart_frame();
        // Hold reset, then release it once for the whole run.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_keys();
        test_empty_frames();
        wait_idle();
        test_tolerance_limits();
        test_long_row();
        test_tall_frame();
        test_output_stall();
        test_random_traffic();

        $display("Sent %0d pixels in %0d frames under %0d key settings; checked %0d records.",
                 pixels_sent, frames_sent, key_settings, records_seen);
        $display("Covered window edges, empty, over-wide and over-tall frames, and backpressure.");
        if (errors == 0 && pending_records.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/ckre_pkg.sv
rtl/ckre_key_match.sv
rtl/ckre_run_tracker.sv
rtl/ckre_result_fifo.sv
rtl/color_key_run_extractor_unit.sv
dv/testbench.sv
